// File: sv/bounded_undo_history_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the checker file of the undo history block.
// Both macros expect signals named clk and arst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_UNDO_HISTORY_MACROS_SVH
`define BOUNDED_UNDO_HISTORY_MACROS_SVH

// Same-cycle implication, checked out of reset only.
`define BUH_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("undo history check failed");

// Next-cycle implication, checked out of reset only.
`define BUH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("undo history check failed");

`endif

// File: sv/buh_pkg.sv
// ----------------------------------------------------------------------------
// buh_pkg
// Shared sizes, codes and payload types of the bounded undo history.
// ----------------------------------------------------------------------------
`default_nettype none

package buh_pkg;

	// Entry slots in the ring and width of one entry word.
	localparam int DEPTH     = 16;
	localparam int WORD_BITS = 32;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CAP_W = 5;
	localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// Operation codes.
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_UNDO = 1'b1;

	// Result kinds.
	localparam logic [1:0] KIND_STORED = 2'd0;
	localparam logic [1:0] KIND_UNDONE = 2'd1;
	localparam logic [1:0] KIND_FORGOT = 2'd2;
	localparam logic [1:0] KIND_EMPTY  = 2'd3;

	typedef struct packed {
		logic                 action;
		logic [WORD_BITS-1:0] entry_value;
	} req_t;

	typedef struct packed {
		logic [1:0]           result_kind;
		logic [WORD_BITS-1:0] result_value;
	} rsp_t;

	// One operation leaving the control stage.
	typedef struct packed {
		logic       fire;
		logic [1:0] kind;
	} issue_t;

endpackage

`default_nettype wire

// File: sv/buh_ram.sv
// ----------------------------------------------------------------------------
// buh_ram
// Generic single-write, single-read RAM with a registered, read-first port.
// ----------------------------------------------------------------------------
`default_nettype none

module buh_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH_N = 16,
	parameter int ADDR_W = (DEPTH_N > 1) ? $clog2(DEPTH_N) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH_N];

	// Read returns the old word when the same entry is written in that cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: sv/buh_ctrl.sv
// ----------------------------------------------------------------------------
// buh_ctrl
// Ring pointer and fill count, capacity register, RAM access issue.
// ----------------------------------------------------------------------------
`default_nettype none

module buh_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire buh_pkg::req_t                 req,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [buh_pkg::CAP_W-1:0]     cfg_data,
	input  wire logic                          busy,
	output logic                               ram_we,
	output logic      [buh_pkg::IDX_W-1:0]     ram_waddr,
	output logic      [buh_pkg::WORD_BITS-1:0] ram_wdata,
	output logic                               ram_re,
	output logic      [buh_pkg::IDX_W-1:0]     ram_raddr,
	output buh_pkg::issue_t                    issue
);
	import buh_pkg::*;

	logic [CAP_W-1:0] cap_q;
	logic [IDX_W-1:0] oldest_q;
	logic [CNT_W-1:0] count_q;

	logic [CMP_W-1:0] cap_ext;
	logic [CMP_W-1:0] cnt_ext;
	logic [CMP_W-1:0] eff_cap;
	logic             full;
	logic             empty;
	logic             accept;
	logic [CNT_W:0]   tail_sum;
	logic [CNT_W:0]   head_sum;
	logic [IDX_W-1:0] tail_slot;
	logic [IDX_W-1:0] head_slot;
	logic [IDX_W-1:0] oldest_inc;
	logic [IDX_W-1:0] oldest_d;
	logic [CNT_W-1:0] count_d;

	assign cfg_ready = 1'b1;
	assign req_stall = busy;
	assign accept    = req_valid && !busy;

	// Clamp capacity into 1..DEPTH.
	assign cap_ext = CMP_W'(cap_q);
	assign cnt_ext = CMP_W'(count_q);
	always_comb begin
		if (cap_ext == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CMP_W'(DEPTH)) begin
			eff_cap = CMP_W'(DEPTH);
		end else begin
			eff_cap = cap_ext;
		end
	end
	assign full  = cnt_ext >= eff_cap;
	assign empty = count_q == '0;

	// Slot after the newest entry, and the newest entry itself.
	assign tail_sum = (CNT_W+1)'(oldest_q) + (CNT_W+1)'(count_q);
	assign head_sum = tail_sum - (CNT_W+1)'(1);
	always_comb begin
		if (tail_sum >= (CNT_W+1)'(DEPTH)) begin
			tail_slot = IDX_W'(tail_sum - (CNT_W+1)'(DEPTH));
		end else begin
			tail_slot = IDX_W'(tail_sum);
		end
		if (head_sum >= (CNT_W+1)'(DEPTH)) begin
			head_slot = IDX_W'(head_sum - (CNT_W+1)'(DEPTH));
		end else begin
			head_slot = IDX_W'(head_sum);
		end
		if (oldest_q == IDX_W'(DEPTH - 1)) begin
			oldest_inc = '0;
		end else begin
			oldest_inc = oldest_q + IDX_W'(1);
		end
	end

	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = tail_slot;
		ram_wdata  = req.entry_value;
		ram_re     = accept;
		ram_raddr  = oldest_q;
		oldest_d   = oldest_q;
		count_d    = count_q;
		issue.fire = accept;
		issue.kind = KIND_STORED;
		case (req.action)
			ACT_UNDO: begin
				ram_raddr = head_slot;
				if (empty) begin
					issue.kind = KIND_EMPTY;
				end else begin
					issue.kind = KIND_UNDONE;
					count_d    = count_q - CNT_W'(1);
				end
			end
			default: begin
				ram_we = accept;
				if (full) begin
					issue.kind = KIND_FORGOT;
					oldest_d   = oldest_inc;
				end else begin
					issue.kind = KIND_STORED;
					count_d    = count_q + CNT_W'(1);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAP_RESET;
			oldest_q <= '0;
			count_q  <= '0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (accept) begin
				oldest_q <= oldest_d;
				count_q  <= count_d;
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/buh_resp.sv
// ----------------------------------------------------------------------------
// buh_resp
// RAM read stage and result register with stall handling.
// ----------------------------------------------------------------------------
`default_nettype none

module buh_resp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire buh_pkg::issue_t               issue,
	input  wire logic [buh_pkg::WORD_BITS-1:0] ram_rdata,
	output logic                               busy,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output buh_pkg::rsp_t                      rsp
);
	import buh_pkg::*;

	logic       valid_s1;
	logic [1:0] kind_s1;
	logic       rsp_valid_q;
	rsp_t       rsp_q;
	logic       adv;
	logic       carries_word;

	assign adv  = !rsp_valid_q || !rsp_stall;
	// Hold the read stage while the result register is stalled; RAM data holds
	// with it because no new read issues.
	assign busy = valid_s1 && !adv;

	assign carries_word = (kind_s1 == KIND_UNDONE) || (kind_s1 == KIND_FORGOT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (!busy) begin
				valid_s1 <= issue.fire;
			end
			if (adv) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy) begin
			kind_s1 <= issue.kind;
		end
		if (adv) begin
			rsp_q.result_kind  <= kind_s1;
			rsp_q.result_value <= carries_word ? ram_rdata : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// File: sv/bounded_undo_history.sv
// ----------------------------------------------------------------------------
// bounded_undo_history
// Bounded undo history: a ring of entry words with push, undo and forget.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req): one operation per transfer.
//     action push stores entry_value as the newest entry; action undo pops
//     the newest entry. Every transfer yields exactly one rsp transfer.
//   rsp channel (rsp_valid / rsp_stall / rsp): result_kind and result_value,
//     in request order.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): capacity, taken every
//     cycle; write it only while no operation is in flight.
//   Path: the request transfer edge issues the RAM read and loads the read
//     stage; the result register, and with it rsp_valid, loads from the read
//     stage when the result register is not stalled.
//   Throughput: one operation per cycle while req_stall is low. Each
//     operation does one read of the entry RAM and a push also writes one
//     entry; count and oldest pointer update in the accepting cycle, so
//     back-to-back operations need no interlock.
//   Reset: history empty, capacity 16. No RAM clearing pass is needed since
//     a word read from an unwritten entry is never returned in rsp.
//   Receiver stall: the result register holds; one more result parks in the
//     read stage, after which req_stall rises until rsp drains.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_undo_history (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      req_valid,
	output logic                           req_stall,
	input  wire buh_pkg::req_t             req,
	output logic                           rsp_valid,
	input  wire logic                      rsp_stall,
	output buh_pkg::rsp_t                  rsp,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [buh_pkg::CAP_W-1:0] cfg_data
);
	import buh_pkg::*;

	logic                 busy;
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [IDX_W-1:0]     ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;
	issue_t               issue;

	// Control: pointer and count update, RAM read/write issue.
	buh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.busy      (busy),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.issue     (issue)
	);

	// Entry store. Read-first, so a forget that overwrites the oldest slot
	// in the same cycle still returns the dropped word.
	buh_ram #(
		.WIDTH   (WORD_BITS),
		.DEPTH_N (DEPTH),
		.ADDR_W  (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Read stage and result register.
	buh_resp u_resp (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.ram_rdata (ram_rdata),
		.busy      (busy),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// File: sv/buh_chk.sv
// ----------------------------------------------------------------------------
// buh_chk
// Port-level checks of the bounded undo history, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_undo_history_macros.svh"

module buh_chk (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire logic          req_stall,
	input  wire logic          rsp_valid,
	input  wire logic          rsp_stall,
	input  wire buh_pkg::rsp_t rsp
);
	import buh_pkg::*;

	logic req_xfer;
	logic no_word;

	assign req_xfer = req_valid && !req_stall;
	assign no_word  = (rsp.result_kind == KIND_STORED) || (rsp.result_kind == KIND_EMPTY);

	// A stalled result holds.
	`BUH_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	// Back-pressure only while the result side is stalled.
	`BUH_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall)
	// A fresh result traces back to a request transfer through the read stage.
	`BUH_ASSERT_NOW(a_rsp_origin, $rose(rsp_valid), $past(req_xfer, 2))
	// Store and empty-undo results carry no word.
	`BUH_ASSERT_NOW(a_zero_value, rsp_valid && no_word, rsp.result_value == '0)

endmodule

bind bounded_undo_history buh_chk u_chk (.*);

`default_nettype wire
